// ===== rtl/mmn_pkg.sv =====
// Package with the shared constants, state type and control structs of the magnetometer normalizer.
package mmn_pkg;

    localparam int FRAC_BITS = 14;
    localparam int SMP_W     = 16;
    localparam int SPAN_W    = 16;
    localparam int QUO_W     = 16;
    localparam int TERM_W    = SMP_W + 2;
    localparam int NUM_W     = TERM_W + FRAC_BITS;
    localparam int DIV_W     = SPAN_W + QUO_W;
    localparam int STEP_W    = $clog2(QUO_W);
    localparam int AXES      = 3;
    localparam int AX_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int MASK_W    = AXES;

    localparam logic signed [SMP_W-1:0] BOUND_LOW_RESET  = -16'sd2048;
    localparam logic signed [SMP_W-1:0] BOUND_HIGH_RESET = 16'sd2047;
    localparam logic signed [SMP_W-1:0] NORM_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] NORM_MIN = 16'sh8000;
    localparam logic [QUO_W-1:0] QUO_POS_LIM = QUO_W'((1 << (QUO_W - 1)) - 1);
    localparam logic [QUO_W-1:0] QUO_NEG_LIM = QUO_W'(1 << (QUO_W - 1));
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);
    localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic            capture;
        logic            load;
        logic            div_step;
        logic            store;
        logic            publish;
        logic [AX_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic skip_div;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/mmn_ctrl.sv =====
// Controller state machine that sequences the three axes through the shared divider.
module mmn_ctrl import mmn_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [AX_W-1:0]   axis_reg, axis_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                axis_next = '0;
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                step_next  = '0;
                state_next = stat.skip_div ? ST_STORE : ST_DIV;
            end
            ST_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (axis_reg == AX_LAST) begin
                    state_next = ST_PUBLISH;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_PUBLISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        cmd.capture  = (state_reg == ST_IDLE) && s_valid;
        cmd.load     = (state_reg == ST_LOAD);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.store    = (state_reg == ST_STORE);
        cmd.publish  = (state_reg == ST_PUBLISH) && stat.out_free;
        cmd.axis     = axis_reg;
    end

endmodule

// ===== rtl/mmn_datapath.sv =====
// Datapath with bound registers, the shared restoring divider and the result registers.
module mmn_datapath import mmn_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic                    s_op,
    input  logic [7:0]              s_x_high_byte,
    input  logic [7:0]              s_x_low_byte,
    input  logic [7:0]              s_z_high_byte,
    input  logic [7:0]              s_z_low_byte,
    input  logic [7:0]              s_y_high_byte,
    input  logic [7:0]              s_y_low_byte,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [SMP_W-1:0]        cfg_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SMP_W-1:0] m_raw_x,
    output logic signed [SMP_W-1:0] m_raw_y,
    output logic signed [SMP_W-1:0] m_raw_z,
    output logic signed [SMP_W-1:0] m_norm_x,
    output logic signed [SMP_W-1:0] m_norm_y,
    output logic signed [SMP_W-1:0] m_norm_z,
    output logic [MASK_W-1:0]       m_zero_span_mask,
    output logic [MASK_W-1:0]       m_clip_mask
);

    logic signed [SMP_W-1:0] lo_reg   [AXES];
    logic signed [SMP_W-1:0] hi_reg   [AXES];
    logic signed [SMP_W-1:0] raw_reg  [AXES];
    logic signed [SMP_W-1:0] norm_reg [AXES];
    logic                    op_reg;
    logic [MASK_W-1:0]       zero_reg;
    logic [MASK_W-1:0]       clip_reg;

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             neg_reg;
    logic             zflag_reg;
    logic             ovf_reg;
    logic             m_valid_reg;

    logic signed [SMP_W-1:0] cur_v, cur_lo, cur_hi;
    logic signed [SMP_W:0]   span;
    logic signed [TERM_W-1:0] term;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_mag;
    logic [SPAN_W-1:0]       span_mag;
    logic [DIV_W-1:0]        dsh_full;
    logic                    span_zero;
    logic                    load_ovf;
    logic                    rem_ge;
    logic signed [SMP_W-1:0] fin_norm;
    logic                    fin_clip;

    assign cur_v  = raw_reg[cmd.axis];
    assign cur_lo = lo_reg[cmd.axis];
    assign cur_hi = hi_reg[cmd.axis];

    always_comb begin
        span      = (SMP_W+1)'(cur_hi) - (SMP_W+1)'(cur_lo);
        term      = (TERM_W'(cur_v) <<< 1) - TERM_W'(cur_lo) - TERM_W'(cur_hi);
        num       = NUM_W'(term) <<< FRAC_BITS;
        num_mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        span_mag  = span[SMP_W] ? SPAN_W'(-span) : SPAN_W'(span);
        dsh_full  = {span_mag, {QUO_W{1'b0}}};
        span_zero = (span == '0);
        load_ovf  = !span_zero && (DIV_W'(num_mag) >= dsh_full);
        rem_ge    = (rem_reg >= dsh_reg);
    end

    assign stat.skip_div = span_zero || load_ovf;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        fin_clip = 1'b0;
        fin_norm = '0;
        priority if (zflag_reg) begin
            fin_norm = '0;
        end else if (ovf_reg) begin
            fin_clip = 1'b1;
            fin_norm = neg_reg ? NORM_MIN : NORM_MAX;
        end else if (neg_reg) begin
            if (quo_reg > QUO_NEG_LIM) begin
                fin_clip = 1'b1;
                fin_norm = NORM_MIN;
            end else begin
                fin_norm = SMP_W'(-$signed(quo_reg));
            end
        end else begin
            if (quo_reg > QUO_POS_LIM) begin
                fin_clip = 1'b1;
                fin_norm = NORM_MAX;
            end else begin
                fin_norm = $signed(quo_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_op;
            raw_reg[0] <= {s_x_high_byte, s_x_low_byte};
            raw_reg[1] <= {s_y_high_byte, s_y_low_byte};
            raw_reg[2] <= {s_z_high_byte, s_z_low_byte};
        end
        if (cmd.load) begin
            rem_reg   <= DIV_W'(num_mag);
            dsh_reg   <= dsh_full >> 1;
            quo_reg   <= '0;
            neg_reg   <= num[NUM_W-1] ^ span[SMP_W];
            zflag_reg <= span_zero;
            ovf_reg   <= load_ovf;
        end
        if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.store) begin
            norm_reg[cmd.axis] <= fin_norm;
            zero_reg[cmd.axis] <= zflag_reg;
            clip_reg[cmd.axis] <= fin_clip;
        end
        if (cmd.publish) begin
            m_raw_x          <= raw_reg[0];
            m_raw_y          <= raw_reg[1];
            m_raw_z          <= raw_reg[2];
            m_norm_x         <= norm_reg[0];
            m_norm_y         <= norm_reg[1];
            m_norm_z         <= norm_reg[2];
            m_zero_span_mask <= zero_reg;
            m_clip_mask      <= clip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                lo_reg[i] <= BOUND_LOW_RESET;
                hi_reg[i] <= BOUND_HIGH_RESET;
            end
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_X_LOW:  lo_reg[0] <= cfg_data;
                REG_X_HIGH: hi_reg[0] <= cfg_data;
                REG_Y_LOW:  lo_reg[1] <= cfg_data;
                REG_Y_HIGH: hi_reg[1] <= cfg_data;
                REG_Z_LOW:  lo_reg[2] <= cfg_data;
                REG_Z_HIGH: hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end else if (cmd.publish && op_reg) begin
            for (int i = 0; i < AXES; i++) begin
                if (raw_reg[i] > hi_reg[i]) begin
                    hi_reg[i] <= raw_reg[i];
                end
                if (raw_reg[i] < lo_reg[i]) begin
                    lo_reg[i] <= raw_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/magnetometer_minmax_normalizer_unit.sv =====
// Top level of the min/max magnetometer normalizer: controller, datapath and checks.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    op and six big-endian sample bytes
//   m_        out        m_valid / m_ready    raw and normalized axes, two masks
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (bound write)
//
// Once a request is accepted, each axis in turn takes one setup step, 16 quotient steps and one
// store step, then the result is loaded into the output register in a publish step that waits
// until that register is free; an axis whose span is zero or whose quotient overflows skips the
// 16 steps. The next request is accepted in the cycle after the result is loaded into the output
// register, even while that result still waits for m_ready; no request is taken before then.
// Synchronous active-low reset returns the bounds to -2048 and 2047 and empties the
// output register; configuration writes are accepted in every cycle.
module magnetometer_minmax_normalizer_unit import mmn_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic [7:0]              s_x_high_byte,
    input  logic [7:0]              s_x_low_byte,
    input  logic [7:0]              s_z_high_byte,
    input  logic [7:0]              s_z_low_byte,
    input  logic [7:0]              s_y_high_byte,
    input  logic [7:0]              s_y_low_byte,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [SMP_W-1:0]        cfg_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SMP_W-1:0] m_raw_x,
    output logic signed [SMP_W-1:0] m_raw_y,
    output logic signed [SMP_W-1:0] m_raw_z,
    output logic signed [SMP_W-1:0] m_norm_x,
    output logic signed [SMP_W-1:0] m_norm_y,
    output logic signed [SMP_W-1:0] m_norm_z,
    output logic [MASK_W-1:0]       m_zero_span_mask,
    output logic [MASK_W-1:0]       m_clip_mask
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    mmn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mmn_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_op             (s_op),
        .s_x_high_byte    (s_x_high_byte),
        .s_x_low_byte     (s_x_low_byte),
        .s_z_high_byte    (s_z_high_byte),
        .s_z_low_byte     (s_z_low_byte),
        .s_y_high_byte    (s_y_high_byte),
        .s_y_low_byte     (s_y_low_byte),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_raw_x          (m_raw_x),
        .m_raw_y          (m_raw_y),
        .m_raw_z          (m_raw_z),
        .m_norm_x         (m_norm_x),
        .m_norm_y         (m_norm_y),
        .m_norm_z         (m_norm_z),
        .m_zero_span_mask (m_zero_span_mask),
        .m_clip_mask      (m_clip_mask)
    );

`ifndef ASSERT_OFF
    // A new result appears only when the controller publishes one.
    a_rose_after_publish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.publish))
        else $error("result valid rose without a publish");

    // Publishing never overwrites a result that has not been taken.
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_valid || m_ready))
        else $error("publish overwrote a pending result");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request accepted while one is in work");

    // An axis with zero span is never also flagged as clipped.
    a_zero_not_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_zero_span_mask & m_clip_mask) == '0))
        else $error("axis flagged both zero span and clipped");
`endif

endmodule
